@@ rtl/sri_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment/rectangle intersect package
// Shared constants, the orientation sign type and small helpers on it.
// ----------------------------------------------------------------------------
package sri_pkg;

    // Default coordinate width of every input field.
    localparam int SRI_COORD_BITS = 16;

    // Sign of an orientation: both flags low means collinear.
    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    // True when two signs are strictly opposite (their product is negative).
    function automatic logic sgn_opposite(input sgn_t a, input sgn_t b);
        return (a.pos && b.neg) || (a.neg && b.pos);
    endfunction

    // True for a zero orientation.
    function automatic logic sgn_zero(input sgn_t a);
        return !a.pos && !a.neg;
    endfunction

endpackage

@@ rtl/sri_if.sv @@
// ----------------------------------------------------------------------------
// Segment/rectangle intersect channels
// Valid/ready channels for query words and result words.
// ----------------------------------------------------------------------------
interface sri_query_if
    import sri_pkg::*;
#(
    parameter int COORD_BITS = SRI_COORD_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] seg_ax;
    logic signed [COORD_BITS-1:0] seg_ay;
    logic signed [COORD_BITS-1:0] seg_bx;
    logic signed [COORD_BITS-1:0] seg_by;
    logic signed [COORD_BITS-1:0] rect_x0;
    logic signed [COORD_BITS-1:0] rect_y0;
    logic signed [COORD_BITS-1:0] rect_x1;
    logic signed [COORD_BITS-1:0] rect_y1;

    modport source (
        output valid, seg_ax, seg_ay, seg_bx, seg_by,
               rect_x0, rect_y0, rect_x1, rect_y1,
        input  ready
    );

    modport sink (
        input  valid, seg_ax, seg_ay, seg_bx, seg_by,
               rect_x0, rect_y0, rect_x1, rect_y1,
        output ready
    );
endinterface

interface sri_result_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (
        output valid, hit,
        input  ready
    );

    modport sink (
        input  valid, hit,
        output ready
    );
endinterface

@@ rtl/sri_hit_eval.sv @@
// ----------------------------------------------------------------------------
// Segment/rectangle hit evaluation
// Turns the four corner cross products into orientation signs and combines
// them with the axis-aligned edge tests into the hit flag.
// ----------------------------------------------------------------------------
module sri_hit_eval
    import sri_pkg::*;
#(
    parameter int CW = SRI_COORD_BITS
)
(
    input  logic signed [CW-1:0]       ax,
    input  logic signed [CW-1:0]       ay,
    input  logic signed [CW-1:0]       bx,
    input  logic signed [CW-1:0]       by,
    input  logic signed [CW-1:0]       xl,
    input  logic signed [CW-1:0]       xh,
    input  logic signed [CW-1:0]       yl,
    input  logic signed [CW-1:0]       yh,
    input  logic signed [2*CW+1:0]     p_dx_yl,
    input  logic signed [2*CW+1:0]     p_dx_yh,
    input  logic signed [2*CW+1:0]     p_dy_xl,
    input  logic signed [2*CW+1:0]     p_dy_xh,
    output logic                       hit
);

    localparam int PW = 2 * CW + 2;

    logic signed [CW-1:0] cx [4];
    logic signed [CW-1:0] cy [4];
    logic signed [PW:0]   corner_turn [4];
    sgn_t                 oc [4];
    logic                 c_in_seg [4];
    logic signed [CW-1:0] px [2];
    logic signed [CW-1:0] py [2];
    sgn_t                 es [2][4];
    logic                 on_e [2][4];
    logic signed [CW-1:0] sx_min, sx_max, sy_min, sy_max;
    logic                 wide_w, wide_h;
    logic                 in_rect;
    logic [3:0]           edge_hit;

    always_comb
    begin
        // Corners in walking order: lower left, upper left, upper right, lower right.
        cx[0] = xl; cy[0] = yl;
        cx[1] = xl; cy[1] = yh;
        cx[2] = xh; cy[2] = yh;
        cx[3] = xh; cy[3] = yl;

        corner_turn[0] = {p_dx_yl[PW-1], p_dx_yl} - {p_dy_xl[PW-1], p_dy_xl};
        corner_turn[1] = {p_dx_yh[PW-1], p_dx_yh} - {p_dy_xl[PW-1], p_dy_xl};
        corner_turn[2] = {p_dx_yh[PW-1], p_dx_yh} - {p_dy_xh[PW-1], p_dy_xh};
        corner_turn[3] = {p_dx_yl[PW-1], p_dx_yl} - {p_dy_xh[PW-1], p_dy_xh};

        sx_min = (ax < bx) ? ax : bx;
        sx_max = (ax < bx) ? bx : ax;
        sy_min = (ay < by) ? ay : by;
        sy_max = (ay < by) ? by : ay;

        for (int k = 0; k < 4; k++)
        begin
            oc[k].neg   = corner_turn[k][PW];
            oc[k].pos   = !corner_turn[k][PW] && (corner_turn[k] != '0);
            c_in_seg[k] = (cx[k] >= sx_min) && (cx[k] <= sx_max) &&
                          (cy[k] >= sy_min) && (cy[k] <= sy_max);
        end

        wide_w = xh > xl;
        wide_h = yh > yl;

        px[0] = ax; py[0] = ay;
        px[1] = bx; py[1] = by;

        // An edge along one axis reduces its orientation test to a product of
        // two signs, so no multiplier is needed for the endpoint side.
        for (int p = 0; p < 2; p++)
        begin
            es[p][0].pos = wide_h && (px[p] < xl);
            es[p][0].neg = wide_h && (px[p] > xl);
            es[p][1].pos = wide_w && (py[p] > yh);
            es[p][1].neg = wide_w && (py[p] < yh);
            es[p][2].pos = wide_h && (px[p] > xh);
            es[p][2].neg = wide_h && (px[p] < xh);
            es[p][3].pos = wide_w && (py[p] < yl);
            es[p][3].neg = wide_w && (py[p] > yl);

            on_e[p][0] = (px[p] == xl) && (py[p] >= yl) && (py[p] <= yh);
            on_e[p][1] = (py[p] == yh) && (px[p] >= xl) && (px[p] <= xh);
            on_e[p][2] = (px[p] == xh) && (py[p] >= yl) && (py[p] <= yh);
            on_e[p][3] = (py[p] == yl) && (px[p] >= xl) && (px[p] <= xh);
        end

        for (int k = 0; k < 4; k++)
        begin
            edge_hit[k] =
                (sgn_opposite(oc[2'(k)], oc[2'(k + 1)]) &&
                 sgn_opposite(es[0][k], es[1][k])) ||
                (sgn_zero(oc[2'(k)]) && c_in_seg[2'(k)]) ||
                (sgn_zero(oc[2'(k + 1)]) && c_in_seg[2'(k + 1)]) ||
                (sgn_zero(es[0][k]) && on_e[0][k]) ||
                (sgn_zero(es[1][k]) && on_e[1][k]);
        end

        // A zero-area rectangle has no interior, which the strict compares give.
        in_rect = ((ax > xl) && (ax < xh) && (ay > yl) && (ay < yh)) ||
                  ((bx > xl) && (bx < xh) && (by > yl) && (by < yh));

        hit = in_rect || (|edge_hit);
    end

endmodule

@@ rtl/segment_rectangle_intersect_unit.sv @@
// ----------------------------------------------------------------------------
// Segment/rectangle intersect unit
// Streams segment versus axis-aligned rectangle hit tests, one per cycle while result.ready keeps up.
// ----------------------------------------------------------------------------
// Usage:
// A query word carries a segment (two endpoints) and a rectangle (two opposite
// corners, in either order). Each query word gives exactly one result word
// whose hit flag is set when an endpoint lies strictly inside the rectangle or
// the segment touches or crosses any of its closed edges.
// Both channels use valid/ready; a word moves on a clock edge where both are
// high. The unit keeps no state between queries.
// The unit takes one query per cycle while result.ready stays high. A query
// passes the four-stage pipeline in order: input register, corner sort and
// differences, the four cross-product multipliers, and the result register
// after the sign evaluation.
// If the receiver holds result.ready low, the result register holds its word
// and the stages behind it keep filling; query.ready falls only once every
// stage is occupied. Reset empties the pipeline; no query is lost or doubled.
// ----------------------------------------------------------------------------
module segment_rectangle_intersect_unit
    import sri_pkg::*;
#(
    parameter int COORD_BITS = SRI_COORD_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    sri_query_if.sink     query,
    sri_result_if.source  result
);

    localparam int CW = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    // Pipeline occupancy and the stall chain running back from the output.
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s0_ready, s1_ready, s2_ready, s3_ready;

    // Stage 0: the query as received.
    logic signed [CW-1:0] s0_ax_reg, s0_ay_reg, s0_bx_reg, s0_by_reg;
    logic signed [CW-1:0] s0_x0_reg, s0_y0_reg, s0_x1_reg, s0_y1_reg;

    // Stage 1: sorted corners, segment direction and corner offsets from A.
    logic signed [CW-1:0] xl_next, xh_next, yl_next, yh_next;
    logic signed [CW-1:0] s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;
    logic signed [CW-1:0] s1_xl_reg, s1_xh_reg, s1_yl_reg, s1_yh_reg;
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg;
    logic signed [DW-1:0] s1_exl_reg, s1_exh_reg, s1_eyl_reg, s1_eyh_reg;

    // Stage 2: the four distinct cross-product terms of the corner tests.
    logic signed [CW-1:0] s2_ax_reg, s2_ay_reg, s2_bx_reg, s2_by_reg;
    logic signed [CW-1:0] s2_xl_reg, s2_xh_reg, s2_yl_reg, s2_yh_reg;
    logic signed [PW-1:0] s2_p_dx_yl_reg, s2_p_dx_yh_reg;
    logic signed [PW-1:0] s2_p_dy_xl_reg, s2_p_dy_xh_reg;

    // Stage 3: the result register.
    logic hit_next;
    logic s3_hit_reg;

    assign s3_ready = !s3_valid_reg || result.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign s0_ready = !s0_valid_reg || s1_ready;

    assign query.ready  = s0_ready;
    assign result.valid = s3_valid_reg;
    assign result.hit   = s3_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_ready)
            begin
                s0_valid_reg <= query.valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_comb
    begin
        xl_next = (s0_x0_reg < s0_x1_reg) ? s0_x0_reg : s0_x1_reg;
        xh_next = (s0_x0_reg < s0_x1_reg) ? s0_x1_reg : s0_x0_reg;
        yl_next = (s0_y0_reg < s0_y1_reg) ? s0_y0_reg : s0_y1_reg;
        yh_next = (s0_y0_reg < s0_y1_reg) ? s0_y1_reg : s0_y0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_ready && query.valid)
        begin
            s0_ax_reg <= query.seg_ax;
            s0_ay_reg <= query.seg_ay;
            s0_bx_reg <= query.seg_bx;
            s0_by_reg <= query.seg_by;
            s0_x0_reg <= query.rect_x0;
            s0_y0_reg <= query.rect_y0;
            s0_x1_reg <= query.rect_x1;
            s0_y1_reg <= query.rect_y1;
        end

        if (s1_ready && s0_valid_reg)
        begin
            s1_ax_reg  <= s0_ax_reg;
            s1_ay_reg  <= s0_ay_reg;
            s1_bx_reg  <= s0_bx_reg;
            s1_by_reg  <= s0_by_reg;
            s1_xl_reg  <= xl_next;
            s1_xh_reg  <= xh_next;
            s1_yl_reg  <= yl_next;
            s1_yh_reg  <= yh_next;
            s1_dx_reg  <= {s0_bx_reg[CW-1], s0_bx_reg} - {s0_ax_reg[CW-1], s0_ax_reg};
            s1_dy_reg  <= {s0_by_reg[CW-1], s0_by_reg} - {s0_ay_reg[CW-1], s0_ay_reg};
            s1_exl_reg <= {xl_next[CW-1], xl_next} - {s0_ax_reg[CW-1], s0_ax_reg};
            s1_exh_reg <= {xh_next[CW-1], xh_next} - {s0_ax_reg[CW-1], s0_ax_reg};
            s1_eyl_reg <= {yl_next[CW-1], yl_next} - {s0_ay_reg[CW-1], s0_ay_reg};
            s1_eyh_reg <= {yh_next[CW-1], yh_next} - {s0_ay_reg[CW-1], s0_ay_reg};
        end

        if (s2_ready && s1_valid_reg)
        begin
            s2_ax_reg      <= s1_ax_reg;
            s2_ay_reg      <= s1_ay_reg;
            s2_bx_reg      <= s1_bx_reg;
            s2_by_reg      <= s1_by_reg;
            s2_xl_reg      <= s1_xl_reg;
            s2_xh_reg      <= s1_xh_reg;
            s2_yl_reg      <= s1_yl_reg;
            s2_yh_reg      <= s1_yh_reg;
            // Corner k orientation is dx*(cy-ay) - dy*(cx-ax); only four
            // distinct products arise across the four corners.
            s2_p_dx_yl_reg <= PW'(s1_dx_reg) * PW'(s1_eyl_reg);
            s2_p_dx_yh_reg <= PW'(s1_dx_reg) * PW'(s1_eyh_reg);
            s2_p_dy_xl_reg <= PW'(s1_dy_reg) * PW'(s1_exl_reg);
            s2_p_dy_xh_reg <= PW'(s1_dy_reg) * PW'(s1_exh_reg);
        end

        if (s3_ready && s2_valid_reg)
        begin
            s3_hit_reg <= hit_next;
        end
    end

    sri_hit_eval #(
        .CW (CW)
    ) u_hit_eval (
        .ax      (s2_ax_reg),
        .ay      (s2_ay_reg),
        .bx      (s2_bx_reg),
        .by      (s2_by_reg),
        .xl      (s2_xl_reg),
        .xh      (s2_xh_reg),
        .yl      (s2_yl_reg),
        .yh      (s2_yh_reg),
        .p_dx_yl (s2_p_dx_yl_reg),
        .p_dx_yh (s2_p_dx_yh_reg),
        .p_dy_xl (s2_p_dy_xl_reg),
        .p_dy_xh (s2_p_dy_xh_reg),
        .hit     (hit_next)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Segment/rectangle intersect unit testbench
// Drives query words through the unit under random flow control, predicts the
// hit flag of every accepted word with exact integer geometry and compares it
// with each result word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import sri_pkg::*;

    localparam int     CW           = SRI_COORD_BITS;
    localparam int     CLK_PERIOD   = 10;
    localparam int     RESET_CYCLES = 6;
    localparam int     MAX_WAIT     = 18;
    // The slowest correct stretch without any transfer is one sender gap plus
    // one receiver stall plus the pipeline depth, far below this limit.
    localparam int     QUIET_LIMIT  = 1000;
    // Leave a margin after the last result for stray words.
    localparam int     DRAIN_CYCLES = 8;
    localparam int     MAX_REPORTS  = 100;
    localparam longint COORD_MAX    = (longint'(1) << (CW - 1)) - 1;
    localparam longint COORD_MIN    = -(longint'(1) << (CW - 1));

    typedef logic signed [CW-1:0]   coord_t;
    // Wide enough for a difference of two cross products without overflow.
    typedef logic signed [2*CW+3:0] wide_t;

    typedef struct {
        coord_t seg_ax;
        coord_t seg_ay;
        coord_t seg_bx;
        coord_t seg_by;
        coord_t rect_x0;
        coord_t rect_y0;
        coord_t rect_x1;
        coord_t rect_y1;
    } query_t;

    typedef struct {
        wide_t x;
        wide_t y;
    } point_t;

    typedef struct {
        query_t q;
        bit     hit;
    } pending_t;

    // How the random part builds a query.
    typedef enum {
        SHAPE_FULL,
        SHAPE_GRID,
        SHAPE_EDGE
    } shape_e;

    logic clk = 1'b0;
    logic rst_n;

    sri_query_if #(.COORD_BITS(CW)) query_bus ();
    sri_result_if                   result_bus ();

    segment_rectangle_intersect_unit #(
        .COORD_BITS(CW)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_bus),
        .result (result_bus)
    );

    // Hit flags still owed by the unit, oldest first.
    pending_t pending_hits[$];
    bit       no_idle;
    int       failures;
    int       reports;
    int       words_sent;
    int       hits_seen;
    int       misses_seen;
    int       quiet_cycles;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Sign of (a - o) x (b - o); zero when the three points are collinear.
    function automatic int orient_sign(point_t o, point_t a, point_t b);
        wide_t turn;
        turn = (a.x - o.x) * (b.y - o.y) - (a.y - o.y) * (b.x - o.x);
        return (turn > 0) ? 1 : ((turn < 0) ? -1 : 0);
    endfunction

    // True when p lies within the bounding box of a and b, edges included.
    function automatic bit in_span(point_t p, point_t a, point_t b);
        return p.x >= ((a.x < b.x) ? a.x : b.x) && p.x <= ((a.x < b.x) ? b.x : a.x) &&
               p.y >= ((a.y < b.y) ? a.y : b.y) && p.y <= ((a.y < b.y) ? b.y : a.y);
    endfunction

    // Closed segments p-q and r-s share at least one point.
    function automatic bit edges_meet(point_t p, point_t q, point_t r, point_t s);
        int o1;
        int o2;
        int o3;
        int o4;
        o1 = orient_sign(p, q, r);
        o2 = orient_sign(p, q, s);
        o3 = orient_sign(r, s, p);
        o4 = orient_sign(r, s, q);
        if (o1 * o2 < 0 && o3 * o4 < 0)
        begin
            return 1'b1;
        end
        // Otherwise only a touching or collinear endpoint can give contact.
        return (o1 == 0 && in_span(r, p, q)) || (o2 == 0 && in_span(s, p, q)) ||
               (o3 == 0 && in_span(p, r, s)) || (o4 == 0 && in_span(q, r, s));
    endfunction

    function automatic bit predict_hit(query_t q);
        point_t a;
        point_t b;
        point_t corner[4];
        wide_t  xl;
        wide_t  xh;
        wide_t  yl;
        wide_t  yh;
        int     k;
        a.x = q.seg_ax;
        a.y = q.seg_ay;
        b.x = q.seg_bx;
        b.y = q.seg_by;
        xl  = (q.rect_x0 < q.rect_x1) ? q.rect_x0 : q.rect_x1;
        xh  = (q.rect_x0 < q.rect_x1) ? q.rect_x1 : q.rect_x0;
        yl  = (q.rect_y0 < q.rect_y1) ? q.rect_y0 : q.rect_y1;
        yh  = (q.rect_y0 < q.rect_y1) ? q.rect_y1 : q.rect_y0;
        // A strict interior test; a flat rectangle never passes it.
        if ((a.x > xl && a.x < xh && a.y > yl && a.y < yh) ||
            (b.x > xl && b.x < xh && b.y > yl && b.y < yh))
        begin
            return 1'b1;
        end
        corner[0] = '{xl, yl};
        corner[1] = '{xl, yh};
        corner[2] = '{xh, yh};
        corner[3] = '{xh, yl};
        for (k = 0; k < 4; k++)
        begin
            if (edges_meet(a, b, corner[k], corner[(k + 1) % 4]))
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic coord_t to_coord(longint v);
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            v = COORD_MIN;
        end
        return coord_t'(v);
    endfunction

    function automatic query_t make_query(longint ax, longint ay, longint bx, longint by,
                                          longint x0, longint y0, longint x1, longint y1);
        query_t q;
        q.seg_ax  = to_coord(ax);
        q.seg_ay  = to_coord(ay);
        q.seg_bx  = to_coord(bx);
        q.seg_by  = to_coord(by);
        q.rect_x0 = to_coord(x0);
        q.rect_y0 = to_coord(y0);
        q.rect_x1 = to_coord(x1);
        q.rect_y1 = to_coord(y1);
        return q;
    endfunction

    // Idle cycles before the next word on either side. Zero is common so that
    // runs of back-to-back transfers appear even in the idling phases.
    function automatic int draw_wait();
        if (no_idle)
        begin
            return 0;
        end
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 2);
            default: return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    function automatic longint grid_coord();
        return longint'($urandom_range(0, 12)) - 6;
    endfunction

    // Rectangle extent: flat, thin, moderate or wide.
    function automatic longint draw_span();
        longint extent;
        case ($urandom_range(0, 3))
            0:       extent = 0;
            1:       extent = $urandom_range(1, 4);
            2:       extent = $urandom_range(5, 200);
            default: extent = $urandom_range(201, 65535);
        endcase
        return $urandom_range(0, 1) ? -extent : extent;
    endfunction

    // A coordinate on, next to or between the bounds lo and hi, sometimes far.
    function automatic longint pick_near(longint lo, longint hi);
        case ($urandom_range(0, 7))
            0:       return lo;
            1:       return hi;
            2:       return lo - 1;
            3:       return hi + 1;
            4:       return lo + 1;
            5:       return hi - 1;
            6:       return lo + longint'($urandom) % (hi - lo + 1);
            default: return longint'(coord_t'($urandom));
        endcase
    endfunction

    function automatic query_t random_query(shape_e shape);
        query_t q;
        longint x0;
        longint y0;
        longint xl;
        longint xh;
        longint yl;
        longint yh;
        case (shape)
            SHAPE_FULL:
            begin
                q.seg_ax  = coord_t'($urandom);
                q.seg_ay  = coord_t'($urandom);
                q.seg_bx  = coord_t'($urandom);
                q.seg_by  = coord_t'($urandom);
                q.rect_x0 = coord_t'($urandom);
                q.rect_y0 = coord_t'($urandom);
                q.rect_x1 = coord_t'($urandom);
                q.rect_y1 = coord_t'($urandom);
            end
            SHAPE_GRID:
            begin
                // A tiny grid makes collinear and touching cases frequent.
                q = make_query(grid_coord(), grid_coord(), grid_coord(), grid_coord(),
                               grid_coord(), grid_coord(), grid_coord(), grid_coord());
            end
            default:
            begin
                x0        = longint'(coord_t'($urandom));
                y0        = longint'(coord_t'($urandom));
                q.rect_x0 = to_coord(x0);
                q.rect_y0 = to_coord(y0);
                q.rect_x1 = to_coord(x0 + draw_span());
                q.rect_y1 = to_coord(y0 + draw_span());
                xl = (q.rect_x0 < q.rect_x1) ? q.rect_x0 : q.rect_x1;
                xh = (q.rect_x0 < q.rect_x1) ? q.rect_x1 : q.rect_x0;
                yl = (q.rect_y0 < q.rect_y1) ? q.rect_y0 : q.rect_y1;
                yh = (q.rect_y0 < q.rect_y1) ? q.rect_y1 : q.rect_y0;
                q.seg_ax = to_coord(pick_near(xl, xh));
                q.seg_ay = to_coord(pick_near(yl, yh));
                q.seg_bx = to_coord(pick_near(xl, xh));
                q.seg_by = to_coord(pick_near(yl, yh));
            end
        endcase
        return q;
    endfunction

    // Presents one query word and returns at the edge where it is taken.
    // Valid is left high so that a following word with no gap streams on.
    task automatic send_query(input query_t q);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            query_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        query_bus.valid   <= 1'b1;
        query_bus.seg_ax  <= q.seg_ax;
        query_bus.seg_ay  <= q.seg_ay;
        query_bus.seg_bx  <= q.seg_bx;
        query_bus.seg_by  <= q.seg_by;
        query_bus.rect_x0 <= q.rect_x0;
        query_bus.rect_y0 <= q.rect_y0;
        query_bus.rect_x1 <= q.rect_x1;
        query_bus.rect_y1 <= q.rect_y1;
        do
            @(posedge clk);
        while (query_bus.ready !== 1'b1);
        words_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Coordinates at the ends of the field range and alternating bit patterns.
    task automatic test_field_extremes();
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_query(make_query(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                              -100, -100, 100, 100));
        send_query(make_query(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MIN + 1, COORD_MIN + 1));
        send_query(make_query(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX,
                              COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
        send_query(make_query(0, 0, 0, 0, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX));
        send_query(make_query(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                              COORD_MIN + 1, COORD_MIN, COORD_MAX, COORD_MAX - 1));
        send_query(make_query(-1, -1, -1, -1, -1, -1, -1, -1));
        send_query(make_query(21845, -21846, -21846, 21845, -21846, -21846, 21845, 21845));
        send_query(make_query(COORD_MAX, COORD_MAX, COORD_MAX - 1, COORD_MIN,
                              COORD_MIN, COORD_MIN, COORD_MAX - 2, COORD_MAX));
    endtask

    // Flat rectangles (a line or a point) and segments that are a single point.
    task automatic test_degenerate_shapes();
        send_query(make_query(5, -5, 5, 5, 0, 0, 10, 0));
        send_query(make_query(5, 1, 5, 5, 0, 0, 10, 0));
        send_query(make_query(8, 0, 20, 0, 0, 0, 10, 0));
        send_query(make_query(11, 0, 20, 0, 0, 0, 10, 0));
        send_query(make_query(0, 0, 6, 6, 3, 3, 3, 3));
        send_query(make_query(0, 0, 6, 7, 3, 3, 3, 3));
        send_query(make_query(5, 5, 5, 5, 0, 0, 10, 10));
        send_query(make_query(10, 4, 10, 4, 0, 0, 10, 10));
        send_query(make_query(11, 4, 11, 4, 0, 0, 10, 10));
    endtask

    // Corners given in every order, a segment grazing a corner, and overlap
    // along an edge.
    task automatic test_touching_and_order();
        send_query(make_query(5, 5, 20, 20, 10, 10, 0, 0));
        send_query(make_query(-5, 5, -1, 5, 10, 0, 0, 10));
        send_query(make_query(5, 15, 15, 5, 0, 0, 10, 10));
        send_query(make_query(6, 15, 15, 6, 0, 0, 10, 10));
        send_query(make_query(-5, 0, 3, 0, 0, 0, 10, 10));
        send_query(make_query(-5, 5, 15, 5, 0, 10, 10, 0));
    endtask

    task automatic test_random_full_range();
        repeat (450) send_query(random_query(SHAPE_FULL));
    endtask

    task automatic test_random_small_grid();
        repeat (500) send_query(random_query(SHAPE_GRID));
    endtask

    // Segments whose ends sit on, beside or between the rectangle bounds.
    task automatic test_random_edge_grazing();
        repeat (650) send_query(random_query(SHAPE_EDGE));
    endtask

    // Both sides without idling, so the pipeline runs full at one per cycle.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (226) send_query(random_query(shape_e'($urandom_range(0, 2))));
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: idles a random number of cycles before each word.
    // ------------------------------------------------------------------------
    initial
    begin : result_receiver
        int stall;
        result_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_bus.valid !== 1'b1);
        end
    end

    // ------------------------------------------------------------------------
    // Checker. Both channels are sampled at the same edge: the result side is
    // handled first, since a query taken at this edge cannot already have its
    // result on the output.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : hit_checker
        pending_t head;
        query_t   taken;
        if (rst_n === 1'b1)
        begin
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                if (pending_hits.size() == 0)
                begin
                    failures++;
                    if (reports < MAX_REPORTS)
                    begin
                        $error("hit: expected no word, got %b", result_bus.hit);
                    end
                    reports++;
                end
                else
                begin
                    head = pending_hits.pop_front();
                    if (result_bus.hit !== head.hit)
                    begin
                        failures++;
                        if (reports < MAX_REPORTS)
                        begin
                            $error("hit: expected %0b, got %b for (%0d,%0d)-(%0d,%0d) in (%0d,%0d)-(%0d,%0d)",
                                   head.hit, result_bus.hit,
                                   head.q.seg_ax, head.q.seg_ay, head.q.seg_bx, head.q.seg_by,
                                   head.q.rect_x0, head.q.rect_y0,
                                   head.q.rect_x1, head.q.rect_y1);
                        end
                        reports++;
                    end
                    if (head.hit)
                    begin
                        hits_seen++;
                    end
                    else
                    begin
                        misses_seen++;
                    end
                end
            end
            if (query_bus.valid === 1'b1 && query_bus.ready === 1'b1)
            begin
                taken.seg_ax  = query_bus.seg_ax;
                taken.seg_ay  = query_bus.seg_ay;
                taken.seg_bx  = query_bus.seg_bx;
                taken.seg_by  = query_bus.seg_by;
                taken.rect_x0 = query_bus.rect_x0;
                taken.rect_y0 = query_bus.rect_y0;
                taken.rect_x1 = query_bus.rect_x1;
                taken.rect_y1 = query_bus.rect_y1;
                pending_hits.push_back('{taken, predict_hit(taken)});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a long stretch with no word moving on either channel means the
    // unit has hung.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if (rst_n === 1'b1)
        begin
            if ((query_bus.valid === 1'b1 && query_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles, %0d results pending",
                         quiet_cycles, pending_hits.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : test_sequence
        no_idle           = 1'b0;
        rst_n             <= 1'b0;
        query_bus.valid   <= 1'b0;
        query_bus.seg_ax  <= '0;
        query_bus.seg_ay  <= '0;
        query_bus.seg_bx  <= '0;
        query_bus.seg_by  <= '0;
        query_bus.rect_x0 <= '0;
        query_bus.rect_y0 <= '0;
        query_bus.rect_x1 <= '0;
        query_bus.rect_y1 <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_degenerate_shapes();
        test_touching_and_order();
        test_random_full_range();
        test_random_small_grid();
        test_random_edge_grazing();
        test_back_to_back();
        query_bus.valid <= 1'b0;

        // The watchdog bounds this wait should the unit stop delivering.
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d query words: %0d hits and %0d misses, %0d mismatches.",
                 words_sent, hits_seen, misses_seen, failures);
        $display("Covered range extremes, flat rectangles, point segments, corner order, %s",
                 "grazing and random traffic with and without idling.");
        if (failures == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
